>>> hdl/gtg_pkg.sv
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared types and tables for the go-to-goal velocity controller.
// ----------------------------------------------------------------------------
package gtg_pkg;

  // Register indexes on the configuration port
  localparam int unsigned REG_INDEX_W = 3;
  localparam logic [REG_INDEX_W-1:0] REG_LINEAR_GAIN      = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_ANGULAR_GAIN     = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_LINEAR_LIMIT     = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_ANGULAR_LIMIT    = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_ARRIVAL_DISTANCE = 3'd4;

  // atan(2^-i) in units of 2^-32 turn
  localparam int unsigned ATAN_DEPTH = 32;
  localparam logic [31:0] ATAN_TURN [ATAN_DEPTH] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Vector in flight through the rotator
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0]        z;
    logic [15:0]        heading;
    logic               zero;     // goal at pose
  } vec_t;

  typedef struct packed {
    logic [15:0] linear_gain;
    logic [15:0] angular_gain;
    logic [30:0] linear_limit;
    logic [30:0] angular_limit;
    logic [23:0] arrival_distance;
  } cfg_t;

endpackage

>>> hdl/gtg_prep.sv
// ----------------------------------------------------------------------------
// gtg_prep
// Input stage: error vector, guard bits and half-plane fold.
// ----------------------------------------------------------------------------
module gtg_prep (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] pose_x,
  input  logic signed [23:0] pose_y,
  input  logic signed [15:0] heading,
  input  logic signed [23:0] target_x,
  input  logic signed [23:0] target_y,
  output logic               out_valid,
  input  logic               out_ready,
  output gtg_pkg::vec_t      out_vec
);

  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  logic signed [24:0] dx;
  logic signed [24:0] dy;
  logic signed [31:0] x_ext;
  logic signed [31:0] y_ext;
  logic               fold;
  gtg_pkg::vec_t      vec_next;
  logic               vld;

  assign dx    = {target_x[23], target_x} - {pose_x[23], pose_x};
  assign dy    = {target_y[23], target_y} - {pose_y[23], pose_y};
  assign x_ext = {{3{dx[24]}}, dx, 4'b0000};
  assign y_ext = {{3{dy[24]}}, dy, 4'b0000};
  assign fold  = dx[24];

  // left half-plane: negate and start half a turn around
  always_comb begin
    vec_next.x       = fold ? -x_ext : x_ext;
    vec_next.y       = fold ? -y_ext : y_ext;
    vec_next.z       = fold ? HALF_TURN : 32'h0;
    vec_next.heading = heading;
    vec_next.zero    = (dx == 25'sd0) && (dy == 25'sd0);
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_vec <= vec_next;
    end
  end

endmodule

>>> hdl/gtg_cordic.sv
// ----------------------------------------------------------------------------
// gtg_cordic
// Unrolled CORDIC vectoring pipeline, one register stage per iteration.
// ----------------------------------------------------------------------------
module gtg_cordic #(
  parameter int unsigned STAGES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  gtg_pkg::vec_t in_vec,
  output logic          out_valid,
  input  logic          out_ready,
  output gtg_pkg::vec_t out_vec
);

  gtg_pkg::vec_t     st [STAGES];
  logic [STAGES-1:0] vld;
  logic [STAGES:0]   rdy;

  assign rdy[STAGES] = out_ready;
  assign in_ready    = rdy[0];
  assign out_valid   = vld[STAGES-1];
  assign out_vec     = st[STAGES-1];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    gtg_pkg::vec_t      src;
    gtg_pkg::vec_t      nxt;
    logic               src_v;
    logic signed [31:0] xs;
    logic signed [31:0] ys;

    if (i == 0) begin : g_first
      assign src   = in_vec;
      assign src_v = in_valid;
    end else begin : g_rest
      assign src   = st[i-1];
      assign src_v = vld[i-1];
    end

    assign xs     = $signed(src.x) >>> i;
    assign ys     = $signed(src.y) >>> i;
    assign rdy[i] = !vld[i] || rdy[i+1];

    always_comb begin
      nxt = src;
      if (src.y[31]) begin
        nxt.x = src.x - ys;
        nxt.y = src.y + xs;
        nxt.z = src.z - gtg_pkg::ATAN_TURN[i];
      end else begin
        nxt.x = src.x + ys;
        nxt.y = src.y - xs;
        nxt.z = src.z + gtg_pkg::ATAN_TURN[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i] <= src_v;
      end
      if (rdy[i] && src_v) begin
        st[i] <= nxt;
      end
    end
  end

endmodule

>>> hdl/gtg_post.sv
// ----------------------------------------------------------------------------
// gtg_post
// Gain removal, heading error, gain products and saturation (four stages).
// ----------------------------------------------------------------------------
module gtg_post (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gtg_pkg::vec_t      in_vec,
  input  gtg_pkg::cfg_t      cfg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] linear_velocity,
  output logic signed [31:0] angular_velocity,
  output logic               goal_reached
);

  localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;  // 1/K, K the CORDIC gain
  localparam logic [31:0] TWO_PI_Q29   = 32'hC90FDAA2;
  localparam logic [62:0] DIST_ROUND   = 63'd1 << 35;
  localparam logic [63:0] RAD_ROUND    = 64'd1 << 40;
  localparam logic [41:0] LIN_ROUND    = 42'd128;
  localparam logic [37:0] ANG_ROUND    = 38'd2048;

  logic [3:0] vld;
  logic [4:0] rdy;

  assign rdy[4]    = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = vld[3];

  for (genvar k = 0; k < 4; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  // stage 1: distance product, wrapped heading error
  logic [62:0] dist_sum;
  logic [31:0] z_eff;
  logic [31:0] err;
  logic [25:0] dist1;
  logic [31:0] mag1;
  logic        neg1;

  assign dist_sum = 63'(in_vec.x[30:0]) * 63'(INV_GAIN_Q32) + DIST_ROUND;
  assign z_eff    = in_vec.zero ? 32'h0 : in_vec.z;
  assign err      = z_eff - {in_vec.heading, 16'h0000};

  // stage 2: radians in Q20
  logic [63:0] rad_sum;
  logic [25:0] dist2;
  logic [21:0] rad2;
  logic        neg2;

  assign rad_sum = 64'(mag1) * 64'(TWO_PI_Q29) + RAD_ROUND;

  // stage 3: gain products
  logic [41:0] lin_sum;
  logic [37:0] ang_sum;
  logic [33:0] lin3;
  logic [25:0] ang3;
  logic        neg3;
  logic        goal3;

  assign lin_sum = 42'(dist2) * 42'(cfg.linear_gain) + LIN_ROUND;
  assign ang_sum = 38'(rad2) * 38'(cfg.angular_gain) + ANG_ROUND;

  // stage 4: saturation
  logic [30:0] lin_sat;
  logic [30:0] ang_sat;

  assign lin_sat = (lin3 > {3'b000, cfg.linear_limit}) ? cfg.linear_limit : lin3[30:0];
  assign ang_sat = ({5'b00000, ang3} > cfg.angular_limit) ? cfg.angular_limit
                                                           : {5'b00000, ang3};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
    end

    if (rdy[0] && in_valid) begin
      dist1 <= in_vec.zero ? 26'd0 : dist_sum[61:36];
      neg1  <= err[31];
      mag1  <= err[31] ? (~err + 32'd1) : err;
    end
    if (rdy[1] && vld[0]) begin
      dist2 <= dist1;
      rad2  <= rad_sum[62:41];
      neg2  <= neg1;
    end
    if (rdy[2] && vld[1]) begin
      lin3  <= lin_sum[41:8];
      ang3  <= ang_sum[37:12];
      neg3  <= neg2;
      goal3 <= dist2 < {2'b00, cfg.arrival_distance};
    end
    if (rdy[3] && vld[2]) begin
      linear_velocity  <= {1'b0, lin_sat};
      angular_velocity <= neg3 ? -$signed({1'b0, ang_sat}) : $signed({1'b0, ang_sat});
      goal_reached     <= goal3;
    end
  end

endmodule

>>> hdl/go_to_goal_velocity_controller_core.sv
// Throughput: one pose per cycle unless the output stalls; the CORDIC rotator has
// one register stage per iteration and the gain path four, all handshaked stage by
// stage. Empty stages keep filling while a result waits at the output.
// Synchronous reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// go_to_goal_velocity_controller_core
// Proportional go-to-goal controller: distance and bearing by CORDIC
// vectoring, clamped forward speed and turn rate, goal reached flag.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_controller_core #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic         clk,
  input  logic         rst,
  // pose_x[23:0], pose_y[47:24], heading[63:48], target_x[87:64], target_y[111:88]
  input  logic [111:0] s_tdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // linear_velocity[31:0], angular_velocity[63:32]
  output logic [63:0]  m_tdata,
  // goal_reached[0]
  output logic         m_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         cfg_write,
  input  logic [gtg_pkg::REG_INDEX_W-1:0] cfg_index,
  input  logic [30:0]  cfg_data
);

  gtg_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.linear_gain      <= 16'd128;
      cfg.angular_gain     <= 16'd512;
      cfg.linear_limit     <= 31'd32768;
      cfg.angular_limit    <= 31'd65536;
      cfg.arrival_distance <= 24'd6554;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gtg_pkg::REG_LINEAR_GAIN:      cfg.linear_gain      <= cfg_data[15:0];
        gtg_pkg::REG_ANGULAR_GAIN:     cfg.angular_gain     <= cfg_data[15:0];
        gtg_pkg::REG_LINEAR_LIMIT:     cfg.linear_limit     <= cfg_data;
        gtg_pkg::REG_ANGULAR_LIMIT:    cfg.angular_limit    <= cfg_data;
        gtg_pkg::REG_ARRIVAL_DISTANCE: cfg.arrival_distance <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  logic          prep_valid;
  logic          prep_ready;
  gtg_pkg::vec_t prep_vec;
  logic          rot_valid;
  logic          rot_ready;
  gtg_pkg::vec_t rot_vec;
  logic signed [31:0] lin_v;
  logic signed [31:0] ang_v;

  gtg_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .pose_x    (s_tdata[23:0]),
    .pose_y    (s_tdata[47:24]),
    .heading   (s_tdata[63:48]),
    .target_x  (s_tdata[87:64]),
    .target_y  (s_tdata[111:88]),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_vec   (prep_vec)
  );

  gtg_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_vec    (prep_vec),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_vec   (rot_vec)
  );

  gtg_post u_post (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (rot_valid),
    .in_ready         (rot_ready),
    .in_vec           (rot_vec),
    .cfg              (cfg),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .linear_velocity  (lin_v),
    .angular_velocity (ang_v),
    .goal_reached     (m_tuser)
  );

  assign m_tdata = {ang_v, lin_v};

  // forward speed comes from unsigned gains only
  a_lin_nonneg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[31])
    else $error("negative linear velocity");

  // turn rate magnitude stays below 2^26 whatever the gain
  a_ang_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[63:58] == 6'b000000) || (m_tdata[63:58] == 6'b111111))
    else $error("angular velocity out of product range");

  // input side only backs up when the whole pipe is full behind a stalled result
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled with room in pipeline");

endmodule

>>> bench/go_to_goal_velocity_controller_core_test.sv
// ----------------------------------------------------------------------------
// go_to_goal_velocity_controller_core_test
// Self-checking bench for the go-to-goal controller core. Pose requests go in
// on the slave stream and velocity commands are checked on the master stream
// against a bit-exact CORDIC/gain predictor. Runs several register settings
// with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_controller_core_test;

  localparam int unsigned STAGES       = 16;
  localparam int unsigned PIPE_LATENCY = STAGES + 5;
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned RAND_PER_PHASE = 150;
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned IDX_W        = gtg_pkg::REG_INDEX_W;
  localparam int unsigned LAST_INDEX   = (1 << IDX_W) - 1;

  localparam logic [15:0] LINEAR_GAIN_RST   = 16'd128;
  localparam logic [15:0] ANGULAR_GAIN_RST  = 16'd512;
  localparam logic [30:0] LINEAR_LIMIT_RST  = 31'd32768;
  localparam logic [30:0] ANGULAR_LIMIT_RST = 31'd65536;
  localparam logic [23:0] ARRIVAL_RST       = 24'd6554;

  localparam logic signed [23:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] COORD_MIN = 24'sh800000;
  localparam logic signed [15:0] HEAD_MAX  = 16'sh7FFF;
  localparam logic signed [15:0] HEAD_MIN  = 16'sh8000;

  localparam logic [31:0] HALF_TURN = 32'h80000000;
  localparam longint unsigned INV_GAIN_Q32 = 64'd2608131496;
  localparam longint unsigned TWO_PI_Q29   = 64'd3373259426;

  // atan(2^-i), 2^-32 turn units
  localparam logic [31:0] ARCTAN [STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  // packs straight onto s_tdata
  typedef struct packed {
    logic signed [23:0] target_y;
    logic signed [23:0] target_x;
    logic signed [15:0] heading;
    logic signed [23:0] pose_y;
    logic signed [23:0] pose_x;
  } pose_req_t;

  typedef struct packed {
    logic               goal;
    logic signed [31:0] angular;
    logic signed [31:0] linear;
  } vel_cmd_t;

  typedef struct {
    pose_req_t req;
    bit        typed;
    vel_cmd_t  cmd;
  } pose_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic [111:0] s_tdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  m_tdata;
  logic         m_tuser;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic         cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [30:0]  cfg_data = '0;

  logic         hold_off = 1'b0;
  logic         rx_steady = 1'b0;
  bit           tx_steady;
  int unsigned  accepted = 0;
  int unsigned  failures = 0;
  gtg_pkg::cfg_t reg_file;
  vel_cmd_t     cmd_q[$];
  pose_row_t    rows[$];

  go_to_goal_velocity_controller_core #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic vel_cmd_t steer_toward_goal(pose_req_t p, gtg_pkg::cfg_t c);
    longint dx, dy, x, y, xs, ys, w, v;
    logic [31:0] z, err;
    longint unsigned dist_q16, mag, rad, wmag;
    bit neg;
    vel_cmd_t r;
    dx = longint'(p.target_x) - longint'(p.pose_x);
    dy = longint'(p.target_y) - longint'(p.pose_y);
    z = '0;
    dist_q16 = 0;
    if (dx != 0 || dy != 0) begin
      x = dx * 16;
      y = dy * 16;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = HALF_TURN;
      end
      for (int i = 0; i < STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y < 0) begin
          x = x - ys;
          y = y + xs;
          z = z - ARCTAN[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + ARCTAN[i];
        end
      end
      dist_q16 = (longint'(unsigned'(x)) * INV_GAIN_Q32 + (64'd1 << 35)) >> 36;
    end
    err = z - {p.heading, 16'h0000};
    neg = err[31];
    mag = neg ? (64'd1 << 32) - {32'h0, err} : {32'h0, err};
    rad = (mag * TWO_PI_Q29 + (64'd1 << 40)) >> 41;
    wmag = (rad * {48'h0, c.angular_gain} + 64'd2048) >> 12;
    w = neg ? -longint'(wmag) : longint'(wmag);
    w = clamp_mag(w, longint'({33'h0, c.angular_limit}));
    v = longint'((dist_q16 * {48'h0, c.linear_gain} + 64'd128) >> 8);
    v = clamp_mag(v, longint'({33'h0, c.linear_limit}));
    r.linear  = v[31:0];
    r.angular = w[31:0];
    r.goal    = dist_q16 < {40'h0, c.arrival_distance};
    return r;
  endfunction

  function automatic vel_cmd_t cmd_of(logic signed [31:0] lin, logic signed [31:0] ang,
                                      logic goal);
    vel_cmd_t r;
    r.linear = lin;
    r.angular = ang;
    r.goal = goal;
    return r;
  endfunction

  task automatic add_row(logic signed [23:0] px, logic signed [23:0] py,
                         logic signed [15:0] hd, logic signed [23:0] tx,
                         logic signed [23:0] ty, bit typed, vel_cmd_t want);
    pose_row_t r;
    r.req.pose_x = px;
    r.req.pose_y = py;
    r.req.heading = hd;
    r.req.target_x = tx;
    r.req.target_y = ty;
    r.typed = typed;
    r.cmd = want;
    rows.push_back(r);
  endtask

  function automatic pose_req_t draw_pose();
    pose_req_t p;
    int ox, oy;
    p.pose_x = 24'($urandom);
    p.pose_y = 24'($urandom);
    p.heading = 16'($urandom);
    p.target_x = 24'($urandom);
    p.target_y = 24'($urandom);
    case ($urandom_range(0, 9))
      4, 5: begin  // around the arrival radius
        ox = int'($urandom_range(0, 16383)) - 8192;
        oy = int'($urandom_range(0, 16383)) - 8192;
        p.target_x = p.pose_x + 24'(ox);
        p.target_y = p.pose_y + 24'(oy);
      end
      6: begin
        ox = int'($urandom_range(0, 262143)) - 131072;
        oy = int'($urandom_range(0, 262143)) - 131072;
        p.target_x = p.pose_x + 24'(ox);
        p.target_y = p.pose_y + 24'(oy);
      end
      7: begin  // axis aligned
        if ($urandom_range(0, 1)) p.target_x = p.pose_x;
        else p.target_y = p.pose_y;
      end
      8: begin
        p.target_x = p.pose_x;
        p.target_y = p.pose_y;
      end
      9: begin
        ox = int'($urandom_range(0, 32)) - 16;
        oy = int'($urandom_range(0, 32)) - 16;
        p.target_x = p.pose_x + 24'(ox);
        p.target_y = p.pose_y + 24'(oy);
      end
      default: ;
    endcase
    return p;
  endfunction

  // one request on the slave stream; expectation queued at the accepting edge
  task automatic offer_pose(pose_req_t p, bit typed, vel_cmd_t want);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= p;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    cmd_q.push_back(typed ? want : steer_toward_goal(p, reg_file));
    accepted++;
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [30:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      gtg_pkg::REG_LINEAR_GAIN:      reg_file.linear_gain = data[15:0];
      gtg_pkg::REG_ANGULAR_GAIN:     reg_file.angular_gain = data[15:0];
      gtg_pkg::REG_LINEAR_LIMIT:     reg_file.linear_limit = data;
      gtg_pkg::REG_ANGULAR_LIMIT:    reg_file.angular_limit = data;
      gtg_pkg::REG_ARRIVAL_DISTANCE: reg_file.arrival_distance = data[23:0];
      default: ;  // unmapped index, ignored
    endcase
  endtask

  function automatic logic [30:0] draw_reg(int ph);
    if (ph == 1) return '1;
    if (ph == 2) return '0;
    if (ph == 3) return 31'($urandom);
    return 31'($urandom >> $urandom_range(1, 31));
  endfunction

  task automatic apply_config(int ph);
    write_reg(gtg_pkg::REG_LINEAR_GAIN, draw_reg(ph));
    write_reg(gtg_pkg::REG_ANGULAR_GAIN, draw_reg(ph));
    write_reg(gtg_pkg::REG_LINEAR_LIMIT, draw_reg(ph));
    write_reg(gtg_pkg::REG_ANGULAR_LIMIT, draw_reg(ph));
    write_reg(gtg_pkg::REG_ARRIVAL_DISTANCE, draw_reg(ph));
    write_reg(IDX_W'($urandom_range(gtg_pkg::REG_ARRIVAL_DISTANCE + 1, LAST_INDEX)),
              31'($urandom));
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: checks each command, then idles a random number of cycles unless rx_steady is set
  always @(posedge clk) begin : velocity_sink
    int rx_wait;
    vel_cmd_t want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (cmd_q.size() == 0) begin
          $error("velocity command with no pose request pending");
          failures++;
        end else begin
          want = cmd_q.pop_front();
          if (m_tdata[31:0] !== want.linear) begin
            $error("linear_velocity: expected %0d, got %0d", want.linear,
                   $signed(m_tdata[31:0]));
            failures++;
          end
          if (m_tdata[63:32] !== want.angular) begin
            $error("angular_velocity: expected %0d, got %0d", want.angular,
                   $signed(m_tdata[63:32]));
            failures++;
          end
          if (m_tuser !== want.goal) begin
            $error("goal_reached: expected %0d, got %0d", want.goal, m_tuser);
            failures++;
          end
        end
        rx_wait = rx_steady ? 0 : $urandom_range(0, 14);
      end
      m_tready <= !hold_off && rx_wait == 0;
      if (rx_wait > 0) rx_wait--;
    end
  end

  // one long output stall so the pipeline backs up into s_tready
  initial begin : output_stall
    wait (accepted >= HOLD_AT);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    vel_cmd_t none;
    none = '0;
    reg_file.linear_gain = LINEAR_GAIN_RST;
    reg_file.angular_gain = ANGULAR_GAIN_RST;
    reg_file.linear_limit = LINEAR_LIMIT_RST;
    reg_file.angular_limit = ANGULAR_LIMIT_RST;
    reg_file.arrival_distance = ARRIVAL_RST;

    // goal at pose, half-turn error, clamped turn rate under reset registers
    add_row(0, 0, 0, 0, 0, 1, cmd_of(0, 0, 1'b1));
    add_row(COORD_MAX, COORD_MAX, HEAD_MIN, COORD_MAX, COORD_MAX, 1,
            cmd_of(0, -32'sd65536, 1'b1));
    add_row(COORD_MIN, COORD_MIN, HEAD_MAX, COORD_MIN, COORD_MIN, 1,
            cmd_of(0, -32'sd65536, 1'b1));
    add_row(COORD_MIN, 0, 0, COORD_MAX, 0, 0, none);
    add_row(COORD_MAX, 0, HEAD_MIN, COORD_MIN, 0, 0, none);
    add_row(0, COORD_MIN, 16'sh4000, 0, COORD_MAX, 0, none);
    add_row(0, COORD_MAX, 16'shC000, 0, COORD_MIN, 0, none);
    add_row(COORD_MIN, COORD_MIN, 0, COORD_MAX, COORD_MAX, 0, none);
    add_row(COORD_MAX, COORD_MAX, HEAD_MIN, COORD_MIN, COORD_MIN, 0, none);
    add_row(COORD_MIN, COORD_MAX, HEAD_MAX, COORD_MAX, COORD_MIN, 0, none);
    add_row(COORD_MAX, COORD_MIN, 16'sh2000, COORD_MIN, COORD_MAX, 0, none);
    add_row(0, 0, 0, 1, 0, 0, none);
    add_row(0, 0, 0, -1, 0, 0, none);
    add_row(0, 0, 1, 0, 1, 0, none);
    add_row(0, 0, -1, 0, -1, 0, none);
    add_row(0, 0, 0, 6553, 0, 0, none);
    add_row(0, 0, 0, 6554, 0, 0, none);
    add_row(0, 0, 0, 6555, 0, 0, none);
    add_row(0, 0, 0, 4634, 4634, 0, none);
    add_row(1, -1, HEAD_MIN, -1, 1, 0, none);
    add_row(COORD_MAX, COORD_MIN, HEAD_MAX, 0, 0, 0, none);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        s_tvalid <= 1'b0;
        while (cmd_q.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
        apply_config(ph);
      end
      tx_steady = (ph % 4) == 1 || (ph % 4) == 3;
      rx_steady <= (ph % 4) == 2 || (ph % 4) == 3;
      if (ph == 0) begin
        foreach (rows[i]) offer_pose(rows[i].req, rows[i].typed, rows[i].cmd);
      end
      repeat (RAND_PER_PHASE) offer_pose(draw_pose(), 0, none);
    end
    s_tvalid <= 1'b0;

    while (cmd_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/gtg_pkg.sv
hdl/gtg_prep.sv
hdl/gtg_cordic.sv
hdl/gtg_post.sv
hdl/go_to_goal_velocity_controller_core.sv
bench/go_to_goal_velocity_controller_core_test.sv
